// ===== hw/rtl/nga_pkg.sv =====
// Shared types and constants of the neighbour gravity accumulator.
package nga_pkg;

   localparam int FRAC_BITS = 16;
   localparam int OUT_FRAC = 24;

   // softening term round(2^(3F) / 10^6) in Q.3F
   localparam logic [95:0] EPS_WIDE =
      ((96'd1 << (3 * FRAC_BITS)) + 96'd500000) / 96'd1000000;
   localparam logic [63:0] EPS = EPS_WIDE[63:0];

   localparam int QUEUE_DEPTH = 2;

   // configuration register indexes
   localparam logic [7:0] CSR_GRAV = 8'd0;
   localparam logic [7:0] CSR_RADIUS = 8'd1;

   // item kinds handed from front to back
   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_SKIP = 2'd1;
   localparam logic [1:0] KIND_ACC = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic        last;
      logic [30:0] ad_x;
      logic [30:0] ad_y;
      logic [30:0] ad_z;
      logic        neg_x;
      logic        neg_y;
      logic        neg_z;
      logic [31:0] mass;
   } item_type;

endpackage

// ===== hw/rtl/nga_front.sv =====
// Front end: holds the target, forms offsets and classifies each beat.
module nga_front import nga_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        command,
   input  logic [31:0] pos_x,
   input  logic [31:0] pos_y,
   input  logic [31:0] pos_z,
   input  logic [31:0] mass,
   input  logic        source_alive,
   input  logic        is_self,
   input  logic        last,
   input  logic [30:0] radius,
   output item_type    item
);

   logic [31:0] target_x_ff, target_y_ff, target_z_ff;
   logic [32:0] dx, dy, dz;
   logic [32:0] ax, ay, az;
   logic        far;

   // form exact 33-bit offsets and their magnitudes
   always_comb begin
      dx = {pos_x[31], pos_x} - {target_x_ff[31], target_x_ff};
      dy = {pos_y[31], pos_y} - {target_y_ff[31], target_y_ff};
      dz = {pos_z[31], pos_z} - {target_z_ff[31], target_z_ff};
      ax = dx[32] ? (33'd0 - dx) : dx;
      ay = dy[32] ? (33'd0 - dy) : dy;
      az = dz[32] ? (33'd0 - dz) : dz;
      far = (ax >= {2'b0, radius}) || (ay >= {2'b0, radius}) || (az >= {2'b0, radius});
   end

   // classify the beat
   always_comb begin
      item.last = last;
      item.ad_x = ax[30:0];
      item.ad_y = ay[30:0];
      item.ad_z = az[30:0];
      item.neg_x = dx[32];
      item.neg_y = dy[32];
      item.neg_z = dz[32];
      item.mass = mass;
      if (!command) begin
         item.kind = KIND_LOAD;
      end else if (source_alive && !is_self && !far) begin
         item.kind = KIND_ACC;
      end else begin
         item.kind = KIND_SKIP;
      end
   end

   // hold the target position
   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff <= '0;
         target_y_ff <= '0;
         target_z_ff <= '0;
      end else if (accept && !command) begin
         target_x_ff <= pos_x;
         target_y_ff <= pos_y;
         target_z_ff <= pos_z;
      end
   end

endmodule

// ===== hw/rtl/nga_queue.sv =====
// Short queue of classified items between front and back.
module nga_queue import nga_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type pop_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ff, rd_ff;
   logic [PTR_W:0]        count_ff;

   assign full = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign pop_item = slot_ff[rd_ff];

   // store pushed items
   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push && !full) begin
            wr_ff <= (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop && !empty) begin
            rd_ff <= (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         count_ff <= count_ff + (PTR_W+1)'(push && !full) - (PTR_W+1)'(pop && !empty);
      end
   end

endmodule

// ===== hw/rtl/nga_back.sv =====
// Back end: sequenced force term per source, saturating sums, result register.
module nga_back import nga_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  item_type    q_item,
   output logic        q_pop,
   input  logic [31:0] grav_const,
   input  logic [30:0] radius,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [47:0] rsp_acc_x,
   output logic [47:0] rsp_acc_y,
   output logic [47:0] rsp_acc_z
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_SQ0  = 5'd1;
   localparam logic [4:0] S_SQ1  = 5'd2;
   localparam logic [4:0] S_SQ2  = 5'd3;
   localparam logic [4:0] S_SQ3  = 5'd4;
   localparam logic [4:0] S_RCHK = 5'd5;
   localparam logic [4:0] S_SQRT = 5'd6;
   localparam logic [4:0] S_DEN0 = 5'd7;
   localparam logic [4:0] S_DEN1 = 5'd8;
   localparam logic [4:0] S_GM   = 5'd9;
   localparam logic [4:0] S_NX0  = 5'd10;
   localparam logic [4:0] S_NX1  = 5'd11;
   localparam logic [4:0] S_NY0  = 5'd12;
   localparam logic [4:0] S_NY1  = 5'd13;
   localparam logic [4:0] S_NZ0  = 5'd14;
   localparam logic [4:0] S_NZ1  = 5'd15;
   localparam logic [4:0] S_DIV0 = 5'd16;
   localparam logic [4:0] S_DIVI = 5'd17;
   localparam logic [4:0] S_DIV  = 5'd18;
   localparam logic [4:0] S_ACC  = 5'd19;
   localparam logic [4:0] S_DONE = 5'd20;

   localparam logic [47:0] MAG_CAP = 48'h8000_0000_0000;
   localparam logic [49:0] SUM_MAX = 50'h0_7FFF_FFFF_FFFF;
   localparam logic [49:0] SUM_MIN = 50'h3_8000_0000_0000;

   logic [4:0]  state_ff, state_in;
   item_type    work_ff;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_ff;
   logic [63:0] r2_ff, sqv_ff, res_ff, bit_ff;
   logic [93:0] den_ff;
   logic [63:0] gm_ff;
   logic [94:0] num_ff [3];
   logic [93:0] rem_ff [3];
   logic [47:0] sh_ff [3];
   logic [47:0] q_ff [3];
   logic        ovf_ff [3];
   logic [5:0]  cnt_ff;
   logic [47:0] sum_ff [3];
   logic        out_valid_ff;
   logic [47:0] out_ff [3];
   logic [63:0] sq_try;
   logic        axis_neg [3];
   logic [94:0] rem_sh [3];
   logic [47:0] mag [3];
   logic [48:0] term [3];
   logic [49:0] sum_wide [3];

   assign q_pop = (state_ff == S_IDLE) && !q_empty;
   assign rsp_empty = !out_valid_ff;
   assign rsp_acc_x = out_ff[0];
   assign rsp_acc_y = out_ff[1];
   assign rsp_acc_z = out_ff[2];

   always_comb begin
      axis_neg[0] = work_ff.neg_x;
      axis_neg[1] = work_ff.neg_y;
      axis_neg[2] = work_ff.neg_z;
   end

   // select multiplier operands for the current step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ0: begin
            mul_a = {1'b0, work_ff.ad_x};
            mul_b = {1'b0, work_ff.ad_x};
         end
         S_SQ1: begin
            mul_a = {1'b0, work_ff.ad_y};
            mul_b = {1'b0, work_ff.ad_y};
         end
         S_SQ2: begin
            mul_a = {1'b0, work_ff.ad_z};
            mul_b = {1'b0, work_ff.ad_z};
         end
         S_SQ3: begin
            mul_a = {1'b0, radius};
            mul_b = {1'b0, radius};
         end
         S_DEN0: begin
            mul_a = r2_ff[31:0];
            mul_b = res_ff[31:0];
         end
         S_DEN1: begin
            mul_a = {2'b0, r2_ff[61:32]};
            mul_b = res_ff[31:0];
         end
         S_GM: begin
            mul_a = grav_const;
            mul_b = work_ff.mass;
         end
         S_NX0: begin
            mul_a = prod_ff[31:0];
            mul_b = {1'b0, work_ff.ad_x};
         end
         S_NX1: begin
            mul_a = gm_ff[63:32];
            mul_b = {1'b0, work_ff.ad_x};
         end
         S_NY0: begin
            mul_a = gm_ff[31:0];
            mul_b = {1'b0, work_ff.ad_y};
         end
         S_NY1: begin
            mul_a = gm_ff[63:32];
            mul_b = {1'b0, work_ff.ad_y};
         end
         S_NZ0: begin
            mul_a = gm_ff[31:0];
            mul_b = {1'b0, work_ff.ad_z};
         end
         S_NZ1: begin
            mul_a = gm_ff[63:32];
            mul_b = {1'b0, work_ff.ad_z};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // register every product
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // per-axis divide step, term cap and saturating sum
   always_comb begin
      sq_try = res_ff + bit_ff;
      for (int i = 0; i < 3; i++) begin
         rem_sh[i] = {rem_ff[i], sh_ff[i][47]};
         mag[i] = (ovf_ff[i] || (q_ff[i] > MAG_CAP)) ? MAG_CAP : q_ff[i];
         term[i] = axis_neg[i] ? (49'd0 - {1'b0, mag[i]}) : {1'b0, mag[i]};
         sum_wide[i] = {{2{sum_ff[i][47]}}, sum_ff[i]} + {term[i][48], term[i]};
      end
   end

   // sequence one item
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               if (q_item.kind == KIND_ACC) begin
                  state_in = S_SQ0;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_RCHK: state_in = (r2_ff < prod_ff) ? S_SQRT : S_DONE;
         S_SQRT: state_in = bit_ff[0] ? S_DEN0 : S_SQRT;
         S_DIV: state_in = (cnt_ff == '0) ? S_ACC : S_DIV;
         S_DONE: begin
            if (!work_ff.last || !out_valid_ff) begin
               state_in = S_IDLE;
            end
         end
         S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_DEN0, S_DEN1, S_GM, S_NX0, S_NX1,
         S_NY0, S_NY1, S_NZ0, S_NZ1, S_DIV0, S_DIVI, S_ACC: begin
            state_in = state_ff + 5'd1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE && !q_empty && q_item.kind == KIND_LOAD) begin
            for (int i = 0; i < 3; i++) begin
               sum_ff[i] <= '0;
            end
         end
         if (state_ff == S_ACC) begin
            for (int i = 0; i < 3; i++) begin
               if ($signed(sum_wide[i]) > $signed(SUM_MAX)) begin
                  sum_ff[i] <= SUM_MAX[47:0];
               end else if ($signed(sum_wide[i]) < $signed(SUM_MIN)) begin
                  sum_ff[i] <= SUM_MIN[47:0];
               end else begin
                  sum_ff[i] <= sum_wide[i][47:0];
               end
            end
         end
         // drop a taken result, then load a new one
         if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         if (state_ff == S_DONE && work_ff.last && !out_valid_ff) begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && work_ff.last && !out_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            out_ff[i] <= sum_ff[i];
         end
      end
      case (state_ff)
         S_IDLE: work_ff <= q_item;
         S_SQ1: r2_ff <= prod_ff;
         S_SQ2, S_SQ3: r2_ff <= r2_ff + prod_ff;
         S_RCHK: begin
            sqv_ff <= r2_ff;
            res_ff <= '0;
            bit_ff <= 64'd1 << 62;
         end
         S_SQRT: begin
            // one root digit a cycle
            if (sqv_ff >= sq_try) begin
               sqv_ff <= sqv_ff - sq_try;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         S_DEN1: den_ff <= {30'd0, prod_ff} + {30'd0, EPS};
         S_GM: den_ff <= den_ff + {prod_ff[61:0], 32'd0};
         S_NX0: gm_ff <= prod_ff;
         S_NX1: num_ff[0] <= {31'd0, prod_ff};
         S_NY0: num_ff[0] <= num_ff[0] + {prod_ff[62:0], 32'd0};
         S_NY1: num_ff[1] <= {31'd0, prod_ff};
         S_NZ0: num_ff[1] <= num_ff[1] + {prod_ff[62:0], 32'd0};
         S_NZ1: num_ff[2] <= {31'd0, prod_ff};
         S_DIV0: num_ff[2] <= num_ff[2] + {prod_ff[62:0], 32'd0};
         S_DIVI: begin
            // split the shifted numerator and flag quotients past 48 bits
            for (int i = 0; i < 3; i++) begin
               rem_ff[i] <= {23'd0, num_ff[i][94:24]};
               sh_ff[i] <= {num_ff[i][23:0], 24'd0};
               q_ff[i] <= '0;
               ovf_ff[i] <= ({23'd0, num_ff[i][94:24]} >= den_ff);
            end
            cnt_ff <= 6'd47;
         end
         S_DIV: begin
            for (int i = 0; i < 3; i++) begin
               if (rem_sh[i] >= {1'b0, den_ff}) begin
                  rem_ff[i] <= 94'(rem_sh[i] - {1'b0, den_ff});
                  q_ff[i] <= {q_ff[i][46:0], 1'b1};
               end else begin
                  rem_ff[i] <= rem_sh[i][93:0];
                  q_ff[i] <= {q_ff[i][46:0], 1'b0};
               end
               sh_ff[i] <= {sh_ff[i][46:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 6'd1;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hw/rtl/neighbour_gravity_accumulator_unit.sv =====
// Top level of the neighbour gravity accumulator: config registers and wiring.
// An accumulating source runs in the back end through a 32-step square root
// and a 48-step divide (three axes divide side by side with one shared
// 32x32 multiplier for the products); a source dropped by the sphere test
// goes to the done state after the radius check, and load and skipped items
// go straight to it. An item marked last also holds the back end until the
// previous result has been popped. A two-entry queue lets new beats enter
// while the back end works, and a finished result waits in its own register.
module neighbour_gravity_accumulator_unit import nga_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_command,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_mass,
   input  logic        req_source_alive,
   input  logic        req_is_self,
   input  logic        req_last,
   output logic        empty,
   input  logic        pop,
   output logic [47:0] rsp_acc_x,
   output logic [47:0] rsp_acc_y,
   output logic [47:0] rsp_acc_z,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [31:0] grav_ff;
   logic [30:0] radius_ff;
   logic        accept;
   item_type    front_item, back_item;
   logic        q_empty, q_pop;

   assign csr_ready = 1'b1;
   assign accept = push && !full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= 32'd65536;
         radius_ff <= 31'd32768;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_GRAV) begin
            grav_ff <= csr_data;
         end else if (csr_index == CSR_RADIUS) begin
            radius_ff <= csr_data[30:0];
         end
      end
   end

   nga_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .command      (req_command),
      .pos_x        (req_pos_x),
      .pos_y        (req_pos_y),
      .pos_z        (req_pos_z),
      .mass         (req_mass),
      .source_alive (req_source_alive),
      .is_self      (req_is_self),
      .last         (req_last),
      .radius       (radius_ff),
      .item         (front_item)
   );

   nga_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (back_item)
   );

   nga_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_item     (back_item),
      .q_pop      (q_pop),
      .grav_const (grav_ff),
      .radius     (radius_ff),
      .rsp_pop    (pop),
      .rsp_empty  (empty),
      .rsp_acc_x  (rsp_acc_x),
      .rsp_acc_y  (rsp_acc_y),
      .rsp_acc_z  (rsp_acc_z)
   );

endmodule
